>>> src/hcs_pkg.sv
`default_nettype none
package hcs_pkg;

    localparam int MAX_DIM    = 128;
    localparam int MAX_RADIUS = 6;

    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
    // signed width for coordinate arithmetic: holds MAX_DIM, the 8-bit registers and offsets
    localparam int XW      = ((DIM_W + 1 > 8) ? DIM_W + 1 : 8) + 2;
    localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
    localparam int CNT_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int SUM_W   = 16 + $clog2(CNT_MAX);
    localparam int QDEPTH  = 4;

    localparam int COL_W      = 7;
    localparam int ROW_W      = 7;
    localparam int HGT_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_CURVE_SHAPE  = 3'd2,
        CFG_LOCAL_EFFECT = 3'd3,
        CFG_LOCAL_AREA   = 3'd4,
        CFG_KEEP_DETAIL  = 3'd5,
        CFG_DETAIL_SIZE  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]        frame_width;
        logic [7:0]        frame_height;
        logic signed [9:0] curve_shape;
        logic [8:0]        local_effect;
        logic [8:0]        local_area;
        logic              keep_detail;
        logic [8:0]        detail_size;
    } cfg_t;

    typedef enum logic {
        ITEM_WRITE   = 1'b0,
        ITEM_COMPUTE = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t              kind;
        logic [COL_W-1:0]        col;
        logic [ROW_W-1:0]        row;
        logic signed [HGT_W-1:0] height;
    } item_t;

    // integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        int          i;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (b > v) begin
                b = b >> 2;
            end
        end
        for (i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // 2^(2^-k) in Q30, built by repeated square roots from 2.0
    function automatic logic [31:0] exp2_entry(input int k);
        logic [63:0] t;
        int          j;
        t = 64'd1 << 31;
        for (j = 1; j <= k; j++) begin
            t = isqrt64(t << 30);
        end
        return t[31:0];
    endfunction

    // samples in a (2r+1) x (2r+1) window
    function automatic logic [CNT_W-1:0] win_count(input logic [RAD_W-1:0] r);
        logic [CNT_W-1:0] side;
        side = CNT_W'({r, 1'b1});
        return CNT_W'(side * side);
    endfunction

endpackage
`default_nettype wire

>>> src/heightfield_curve_shaper.sv
`default_nettype none
// The back end works on one item at a time. Compute with detail on is paced by the
// one-read-per-cycle window sweep (R = box radius 1..6) and a 24-step divider; with detail
// off it is paced by the 16-step log2 and exp2 loops of the power unit.
// Reset (aresetn, synchronous, active low) clears control state and restores register defaults;
// the height store keeps its contents and needs no clearing pass.
module heightfield_curve_shaper (
    input  wire          aclk,
    input  wire          aresetn,
    // input stream
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [31:0]  s_tdata,    // col_index[6:0], row_index[13:7], height_in[29:14]
    input  wire          s_tuser,    // operation: 0 write sample, 1 compute
    // result stream
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [31:0]  m_tdata,    // out_height[15:0], out_col[22:16], out_row[29:23]
    // register writes
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [2:0]   cfg_addr,
    input  wire  [9:0]   cfg_wdata
);

    hcs_pkg::cfg_t   cfg_reg;
    logic            q_valid;
    hcs_pkg::item_t  q_item;
    logic            q_pop;
    logic [15:0]     out_height;
    logic [6:0]      out_col;
    logic [6:0]      out_row;

    // registers always take a write
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= 8'd128;
            cfg_reg.frame_height <= 8'd128;
            cfg_reg.curve_shape  <= '0;
            cfg_reg.local_effect <= '0;
            cfg_reg.local_area   <= 9'd128;
            cfg_reg.keep_detail  <= 1'b1;
            cfg_reg.detail_size  <= 9'd64;
        end else if (cfg_valid && cfg_ready) begin
            // drop writes beyond the register list
            unique case (hcs_pkg::cfg_index_t'(cfg_addr))
                hcs_pkg::CFG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_wdata[7:0];
                hcs_pkg::CFG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_wdata[7:0];
                hcs_pkg::CFG_CURVE_SHAPE:  cfg_reg.curve_shape  <= cfg_wdata;
                hcs_pkg::CFG_LOCAL_EFFECT: cfg_reg.local_effect <= cfg_wdata[8:0];
                hcs_pkg::CFG_LOCAL_AREA:   cfg_reg.local_area   <= cfg_wdata[8:0];
                hcs_pkg::CFG_KEEP_DETAIL:  cfg_reg.keep_detail  <= cfg_wdata[0];
                hcs_pkg::CFG_DETAIL_SIZE:  cfg_reg.detail_size  <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // front: accept, classify and queue transactions
    hcs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back: height store, window sweep, power curve, blend and output register
    hcs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_height (out_height),
        .out_col    (out_col),
        .out_row    (out_row)
    );

    assign m_tdata = {2'b00, out_row, out_col, out_height};

endmodule
`default_nettype wire

>>> src/hcs_front.sv
`default_nettype none
module hcs_front (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [31:0]                  s_tdata,   // col_index[6:0], row_index[13:7], height_in[29:14]
    input  wire                          s_tuser,   // operation
    output logic                         q_valid,
    output hcs_pkg::item_t               q_item,
    input  wire                          q_pop
);

    localparam int PTR_W = $clog2(hcs_pkg::QDEPTH);

    hcs_pkg::item_t             q_mem [hcs_pkg::QDEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [PTR_W:0]             count_reg;
    hcs_pkg::item_t             item_c;
    logic                       drop_c;
    logic                       push_c;
    logic                       pop_c;

    always_comb begin
        item_c.kind   = s_tuser ? hcs_pkg::ITEM_COMPUTE : hcs_pkg::ITEM_WRITE;
        item_c.col    = s_tdata[6:0];
        item_c.row    = s_tdata[13:7];
        item_c.height = s_tdata[29:14];
    end

    // drop writes that fall outside the store
    assign drop_c = (item_c.kind == hcs_pkg::ITEM_WRITE) &&
                    ((hcs_pkg::XW'(item_c.col) >= hcs_pkg::XW'(hcs_pkg::MAX_DIM)) ||
                     (hcs_pkg::XW'(item_c.row) >= hcs_pkg::XW'(hcs_pkg::MAX_DIM)));

    assign s_tready = (count_reg != (PTR_W+1)'(hcs_pkg::QDEPTH));
    assign push_c   = s_tvalid && s_tready && !drop_c;
    assign pop_c    = q_pop && q_valid;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push_c) begin
            q_mem[wr_ptr_reg] <= item_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_c) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_c) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_c && !pop_c) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop_c && !push_c) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PTR_W+1)'(hcs_pkg::QDEPTH))
        else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

>>> src/hcs_pow.sv
`default_nettype none
module hcs_pow (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          start,
    input  wire  [15:0]  n16,
    input  wire  [17:0]  expo,
    output logic         done,
    output logic [16:0]  pw
);

    localparam logic [31:0] EXP2_TAB [16] = '{
        hcs_pkg::exp2_entry(1),  hcs_pkg::exp2_entry(2),
        hcs_pkg::exp2_entry(3),  hcs_pkg::exp2_entry(4),
        hcs_pkg::exp2_entry(5),  hcs_pkg::exp2_entry(6),
        hcs_pkg::exp2_entry(7),  hcs_pkg::exp2_entry(8),
        hcs_pkg::exp2_entry(9),  hcs_pkg::exp2_entry(10),
        hcs_pkg::exp2_entry(11), hcs_pkg::exp2_entry(12),
        hcs_pkg::exp2_entry(13), hcs_pkg::exp2_entry(14),
        hcs_pkg::exp2_entry(15), hcs_pkg::exp2_entry(16)
    };

    typedef enum logic [4:0] {
        P_IDLE  = 5'b00001,
        P_LOG   = 5'b00010,
        P_SCALE = 5'b00100,
        P_EXP   = 5'b01000,
        P_ROUND = 5'b10000
    } pow_state_t;

    pow_state_t    state_reg;
    pow_state_t    state_next;
    logic [3:0]    step_reg;
    logic [3:0]    p_reg;
    logic [31:0]   m_reg;
    logic [15:0]   frac_reg;
    logic [17:0]   e_reg;
    logic [22:0]   q_reg;
    logic [31:0]   r_reg;
    logic          done_reg;
    logic [16:0]   pw_reg;

    logic [3:0]    p_c;
    logic [63:0]   sq_c;
    logic [31:0]   mm_c;
    logic [20:0]   nl_c;
    logic [39:0]   qp_c;
    logic [15:0]   g_c;
    logic [63:0]   rt_c;
    logic [7:0]    sh_c;
    logic [32:0]   rnd_c;
    logic [16:0]   pw_c;

    always_comb begin
        p_c = '0;
        for (int i = 0; i < 16; i++) begin
            if (n16[i]) begin
                p_c = 4'(i);
            end
        end
    end

    assign sq_c = 64'(m_reg) * 64'(m_reg);
    assign mm_c = sq_c[61:30];
    assign nl_c = {5'd16 - {1'b0, p_reg}, 16'd0} - {5'd0, frac_reg};
    assign qp_c = 40'(nl_c) * 40'(e_reg) + 40'd32768;
    assign g_c  = (q_reg[15:0] == '0) ? 16'd0 : 16'(17'd65536 - {1'b0, q_reg[15:0]});
    assign rt_c = 64'(r_reg) * 64'(EXP2_TAB[step_reg]);
    assign sh_c = ((q_reg[15:0] == '0) ? 8'd14 : 8'd15) + {1'b0, q_reg[22:16]};

    always_comb begin
        rnd_c = '0;
        pw_c  = '0;
        if (sh_c < 8'd32) begin
            rnd_c = ({1'b0, r_reg} + (33'd1 << (sh_c - 8'd1))) >> sh_c;
            pw_c  = (rnd_c > 33'd65536) ? 17'd65536 : rnd_c[16:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            P_IDLE:  if (start && (n16 != '0)) state_next = P_LOG;
            P_LOG:   if (step_reg == 4'd15) state_next = P_SCALE;
            P_SCALE: state_next = P_EXP;
            P_EXP:   if (step_reg == 4'd15) state_next = P_ROUND;
            P_ROUND: state_next = P_IDLE;
            default: state_next = P_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == P_IDLE && start) begin
                done_reg <= (n16 == '0);
            end else if (state_reg == P_ROUND) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == P_IDLE && start) begin
            p_reg    <= p_c;
            m_reg    <= 32'(n16) << (5'd30 - {1'b0, p_c});
            frac_reg <= '0;
            e_reg    <= expo;
            step_reg <= '0;
            pw_reg   <= '0;
        end
        if (state_reg == P_LOG) begin
            step_reg <= step_reg + 1'b1;
            if (mm_c[31]) begin
                m_reg                         <= mm_c >> 1;
                frac_reg[4'd15 - step_reg]    <= 1'b1;
            end else begin
                m_reg <= mm_c;
            end
        end
        if (state_reg == P_SCALE) begin
            q_reg    <= qp_c[38:16];
            r_reg    <= 32'd1 << 30;
            step_reg <= '0;
        end
        if (state_reg == P_EXP) begin
            step_reg <= step_reg + 1'b1;
            if (g_c[4'd15 - step_reg]) begin
                r_reg <= rt_c[61:30];
            end
        end
        if (state_reg == P_ROUND) begin
            pw_reg <= pw_c;
        end
    end

    assign done = done_reg;
    assign pw   = pw_reg;

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (state_reg == P_IDLE))
        else $error("power unit flags done while busy");
`endif

endmodule
`default_nettype wire

>>> src/hcs_back.sv
`default_nettype none
module hcs_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  hcs_pkg::cfg_t       cfg,
    input  wire                 q_valid,
    input  hcs_pkg::item_t      q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [15:0]         out_height,
    output logic [6:0]          out_col,
    output logic [6:0]          out_row
);

    localparam int XW    = hcs_pkg::XW;
    localparam int RAD_W = hcs_pkg::RAD_W;
    localparam int CNT_W = hcs_pkg::CNT_W;
    localparam int SUM_W = hcs_pkg::SUM_W;
    localparam int DC_W  = $clog2(SUM_W);

    typedef enum logic [7:0] {
        B_IDLE   = 8'b00000001,
        B_CENTER = 8'b00000010,
        B_SWEEP  = 8'b00000100,
        B_DIV    = 8'b00001000,
        B_POW    = 8'b00010000,
        B_SCALE  = 8'b00100000,
        B_ROUND  = 8'b01000000,
        B_OUT    = 8'b10000000
    } back_state_t;

    function automatic logic [hcs_pkg::ADDR_W-1:0] cell_addr(
        input logic signed [XW-1:0] x,
        input logic signed [XW-1:0] y
    );
        return hcs_pkg::ADDR_W'(y * hcs_pkg::MAX_DIM + x);
    endfunction

    function automatic logic signed [XW-1:0] clamp_coord(
        input logic signed [XW-1:0] v,
        input logic signed [XW-1:0] lim
    );
        if (v < 0) begin
            return '0;
        end else if (v > lim - 1) begin
            return lim - 1;
        end
        return v;
    endfunction

    logic [15:0] mem [hcs_pkg::MAX_DIM * hcs_pkg::MAX_DIM];
    logic [15:0] mem_rdata_reg;
    logic        mem_we;
    logic [hcs_pkg::ADDR_W-1:0] mem_waddr;
    logic [hcs_pkg::ADDR_W-1:0] mem_raddr;

    back_state_t               state_reg;
    back_state_t               state_next;
    logic signed [XW-1:0]      w_reg;
    logic signed [XW-1:0]      h_reg;
    logic signed [XW-1:0]      cx_reg;
    logic signed [XW-1:0]      cy_reg;
    logic [6:0]                col_reg;
    logic [6:0]                row_reg;
    logic [RAD_W-1:0]          rad_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [17:0]               e_reg;
    logic [8:0]                le_reg;
    logic [8:0]                la_reg;
    logic                      kd_reg;
    logic signed [15:0]        c_reg;
    logic signed [RAD_W:0]     dx_reg;
    logic signed [RAD_W:0]     dy_reg;
    logic                      issued_all_reg;
    logic                      rd_v_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]          num_reg;
    logic [CNT_W-1:0]          rem_reg;
    logic [DC_W-1:0]           div_cnt_reg;
    logic                      sign_reg;
    logic signed [17:0]        shaped_reg;
    logic [25:0]               t_reg;
    logic signed [44:0]        prod_reg;
    logic signed [21:0]        acc_reg;
    logic                      out_valid_reg;
    logic [15:0]               out_height_reg;
    logic [6:0]                out_col_reg;
    logic [6:0]                out_row_reg;

    logic                      pow_done;
    logic [16:0]               pow_pw;

    // item decode and register clamps
    logic signed [XW-1:0] fw_x, fh_x, w_c, h_c, colx_c, rowx_c, cx_c, cy_c;
    logic [8:0]           ds_c;
    logic [10:0]          rnd_c;
    logic [3:0]           rad_full_c;
    logic [RAD_W-1:0]     rad_c;
    logic signed [9:0]    s_c;
    logic [24:0]          sm_c;
    logic [17:0]          e_c;

    always_comb begin
        fw_x   = XW'(cfg.frame_width);
        fh_x   = XW'(cfg.frame_height);
        w_c    = (fw_x == 0) ? XW'(1) :
                 (fw_x > XW'(hcs_pkg::MAX_DIM)) ? XW'(hcs_pkg::MAX_DIM) : fw_x;
        h_c    = (fh_x == 0) ? XW'(1) :
                 (fh_x > XW'(hcs_pkg::MAX_DIM)) ? XW'(hcs_pkg::MAX_DIM) : fh_x;
        colx_c = XW'(q_item.col);
        rowx_c = XW'(q_item.row);
        cx_c   = clamp_coord(colx_c, w_c);
        cy_c   = clamp_coord(rowx_c, h_c);

        ds_c       = (cfg.detail_size > 9'd256) ? 9'd256 : cfg.detail_size;
        rnd_c      = (11'(ds_c) * 11'd5 + 11'd128) >> 8;
        rad_full_c = 4'd1 + rnd_c[3:0];
        rad_c      = (rad_full_c > 4'(hcs_pkg::MAX_RADIUS)) ?
                     RAD_W'(hcs_pkg::MAX_RADIUS) : RAD_W'(rad_full_c);

        s_c  = (cfg.curve_shape > 10'sd256) ? 10'sd256 :
               (cfg.curve_shape < -10'sd256) ? -10'sd256 : cfg.curve_shape;
        sm_c = 25'd42598 * 25'(s_c[8:0]) + 25'd128;
        if (s_c >= 0) begin
            e_c = 18'd65536 - 18'(sm_c[24:8]);
        end else begin
            e_c = 18'd65536 + 18'({9'(-s_c), 9'd0});
        end
    end

    // window walk
    logic                      issue_c;
    logic signed [XW-1:0]      wx_c, wy_c;
    logic signed [RAD_W:0]     rads_c;

    assign rads_c  = signed'({1'b0, rad_reg});
    assign issue_c = ((state_reg == B_CENTER) && kd_reg) ||
                     ((state_reg == B_SWEEP) && !issued_all_reg);
    assign wx_c    = clamp_coord(cx_reg + XW'(dx_reg), w_reg);
    assign wy_c    = clamp_coord(cy_reg + XW'(dy_reg), h_reg);

    assign q_pop     = (state_reg == B_IDLE) && q_valid;
    assign mem_we    = q_pop && (q_item.kind == hcs_pkg::ITEM_WRITE);
    assign mem_waddr = cell_addr(colx_c, rowx_c);
    assign mem_raddr = (state_reg == B_IDLE) ? cell_addr(cx_c, cy_c) : cell_addr(wx_c, wy_c);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= q_item.height;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    // power unit
    hcs_pow u_pow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == B_CENTER),
        .n16     ({~mem_rdata_reg[15], mem_rdata_reg[14:0]}),
        .expo    (e_reg),
        .done    (pow_done),
        .pw      (pow_pw)
    );

    // divider step
    logic [CNT_W:0]          trial_c;
    logic                    ge_c;
    logic [CNT_W:0]          rem_c;
    logic [SUM_W-1:0]        mag_c;

    assign trial_c = {rem_reg, num_reg[SUM_W-1]};
    assign ge_c    = (trial_c >= {1'b0, cnt_reg});
    assign rem_c   = ge_c ? (trial_c - {1'b0, cnt_reg}) : trial_c;
    assign mag_c   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    // blend arithmetic
    logic [15:0]          n16_c;
    logic signed [18:0]   dl_c;
    logic [18:0]          dabs_c;
    logic [20:0]          d4_c;
    logic [16:0]          wt_c;
    logic signed [18:0]   diff_c;
    logic [44:0]          pmag_c;
    logic [44:0]          pr_c;
    logic signed [21:0]   rq_c;
    logic signed [17:0]   mean_c;
    logic signed [21:0]   total_c;
    logic [15:0]          sat_c;

    always_comb begin
        n16_c  = {~c_reg[15], c_reg[14:0]};
        dl_c   = signed'({3'b0, n16_c}) - signed'({2'b0, la_reg, 8'd0});
        dabs_c = dl_c[18] ? 19'(-dl_c) : 19'(dl_c);
        d4_c   = {dabs_c[18:0], 2'b00};
        wt_c   = (d4_c >= 21'd65536) ? 17'd0 : 17'(21'd65536 - d4_c);
        diff_c = 19'(shaped_reg) - 19'(c_reg);
        pmag_c = prod_reg[44] ? 45'(-prod_reg) : 45'(prod_reg);
        pr_c   = pmag_c + (45'd1 << 23);
        rq_c   = prod_reg[44] ? -signed'(22'(pr_c[44:24])) : signed'(22'(pr_c[44:24]));
        mean_c = sign_reg ? -signed'({2'b0, num_reg[15:0]}) : signed'({2'b0, num_reg[15:0]});
        total_c = acc_reg + (kd_reg ? (22'(c_reg) - 22'(mean_c)) : 22'sd0);
        if (total_c > 22'sd32767) begin
            sat_c = 16'h7FFF;
        end else if (total_c < -22'sd32768) begin
            sat_c = 16'h8000;
        end else begin
            sat_c = total_c[15:0];
        end
    end

    logic out_load_c;
    assign out_load_c = (state_reg == B_OUT) && (!out_valid_reg || out_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:   if (q_pop && q_item.kind == hcs_pkg::ITEM_COMPUTE) state_next = B_CENTER;
            B_CENTER: state_next = kd_reg ? B_SWEEP : B_POW;
            B_SWEEP:  if (issued_all_reg && !rd_v_reg) state_next = B_DIV;
            B_DIV:    if (div_cnt_reg == DC_W'(SUM_W - 1)) state_next = B_POW;
            B_POW:    if (pow_done) state_next = B_SCALE;
            B_SCALE:  state_next = B_ROUND;
            B_ROUND:  state_next = B_OUT;
            B_OUT:    if (out_load_c) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            rd_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rd_v_reg  <= issue_c;
            if (out_load_c) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_IDLE && q_pop) begin
            w_reg          <= w_c;
            h_reg          <= h_c;
            cx_reg         <= cx_c;
            cy_reg         <= cy_c;
            col_reg        <= q_item.col;
            row_reg        <= q_item.row;
            rad_reg        <= rad_c;
            cnt_reg        <= hcs_pkg::win_count(rad_c);
            e_reg          <= e_c;
            le_reg         <= (cfg.local_effect > 9'd256) ? 9'd256 : cfg.local_effect;
            la_reg         <= (cfg.local_area > 9'd256) ? 9'd256 : cfg.local_area;
            kd_reg         <= cfg.keep_detail;
            dx_reg         <= -signed'({1'b0, rad_c});
            dy_reg         <= -signed'({1'b0, rad_c});
            issued_all_reg <= 1'b0;
        end
        if (state_reg == B_CENTER) begin
            c_reg   <= mem_rdata_reg;
            sum_reg <= '0;
        end
        if (issue_c) begin
            if (dx_reg == rads_c) begin
                dx_reg <= -rads_c;
                dy_reg <= dy_reg + 1'b1;
                if (dy_reg == rads_c) begin
                    issued_all_reg <= 1'b1;
                end
            end else begin
                dx_reg <= dx_reg + 1'b1;
            end
        end
        if (state_reg == B_SWEEP) begin
            if (rd_v_reg) begin
                sum_reg <= sum_reg + SUM_W'(signed'(mem_rdata_reg));
            end
            if (issued_all_reg && !rd_v_reg) begin
                // set up |sum| + count/2, divided by count
                num_reg     <= mag_c + SUM_W'(cnt_reg >> 1);
                sign_reg    <= sum_reg[SUM_W-1];
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
        end
        if (state_reg == B_DIV) begin
            rem_reg     <= rem_c[CNT_W-1:0];
            num_reg     <= {num_reg[SUM_W-2:0], ge_c};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (state_reg == B_POW && pow_done) begin
            shaped_reg <= signed'({1'b0, pow_pw}) - 18'sd32768;
            t_reg      <= 26'(le_reg) * 26'(wt_c);
        end
        if (state_reg == B_SCALE) begin
            prod_reg <= 45'(diff_c) * 45'(signed'({1'b0, t_reg}));
        end
        if (state_reg == B_ROUND) begin
            acc_reg <= (le_reg == '0) ? 22'(shaped_reg) : (22'(c_reg) + rq_c);
        end
        if (out_load_c) begin
            out_height_reg <= sat_c;
            out_col_reg    <= col_reg;
            out_row_reg    <= row_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_height = out_height_reg;
    assign out_col    = out_col_reg;
    assign out_row    = out_row_reg;

`ifndef NO_ASSERTIONS
    a_read_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_v_reg |-> (state_reg == B_SWEEP))
        else $error("window sample returned outside the sweep");
    a_pow_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_SCALE) |-> pow_done)
        else $error("blend started before the power result");
    a_out_from_final: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == B_OUT))
        else $error("result raised outside the final step");
`endif

endmodule
`default_nettype wire
